FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked while reset is released
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: hdl/svpt_pkg.sv
// ---------------------------------------------------------------------------
// svpt_pkg
// types and constants of the space vector pwm timing block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svpt_pkg;

  localparam int MOD_BITS   = 16;
  localparam int TIMER_BITS = 16;
  // fraction bits of the products: q1.15 input times q1.16 constants
  localparam int FRAC_BITS  = MOD_BITS - 1 + 16;
  localparam int CONST_W    = 18;
  localparam int PROD_W     = MOD_BITS + CONST_W;
  localparam int MAG_W      = MOD_BITS + 16;
  localparam int RAW_W      = MAG_W + TIMER_BITS - FRAC_BITS;

  // 1/sqrt3 and 2/sqrt3 in signed q1.16
  localparam logic signed [CONST_W-1:0] K_INV_SQRT3     = 18'sd37837;
  localparam logic signed [CONST_W-1:0] K_TWO_INV_SQRT3 = 18'sd75674;

  localparam logic [TIMER_BITS-1:0] HALF_PERIOD_RST = 16'd4096;

  typedef enum logic [2:0] {
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5,
    SEC_6 = 3'd6
  } sector_e;

  typedef struct packed {
    logic signed [MOD_BITS-1:0] alpha;
    logic signed [MOD_BITS-1:0] beta;
  } in_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] compare_a;
    logic [TIMER_BITS-1:0] compare_b;
    logic [TIMER_BITS-1:0] compare_c;
    logic [2:0]            sector;
    logic                  saturated;
  } out_t;

endpackage

FILE: hdl/space_vector_pwm_timing.sv
// throughput: one request per cycle while the output is not stalled, five register stages with valid bits
// stages: constant products, sector and projections, half period multiply,
//   on-time clamp and zero-vector time, running sums and phase order
// reset clears all stage valid bits and sets the half period to 4096
// ---------------------------------------------------------------------------
// space_vector_pwm_timing
// svpwm sector detection and centre-aligned compare values
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module space_vector_pwm_timing (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  svpt_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output svpt_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [svpt_pkg::TIMER_BITS-1:0]   cfg_wdata_i
);
  import svpt_pkg::*;

  logic [TIMER_BITS-1:0] h_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1 registers
  logic signed [PROD_W-1:0] s1_a_d, s1_kb_d, s1_k2b_d;
  logic signed [PROD_W-1:0] s1_a_q, s1_kb_q, s1_k2b_q;

  // stage 2 registers
  logic signed [PROD_W-1:0] dif, sum;
  sector_e                  s2_sector_d, s2_sector_q;
  logic [MAG_W-1:0]         s2_mag_d_d, s2_mag_s_d, s2_mag_k_d;
  logic [MAG_W-1:0]         s2_mag_d_q, s2_mag_s_q, s2_mag_k_q;
  logic                     s2_neg_d_q, s2_neg_s_q, s2_neg_k_q;

  // stage 3 registers
  logic [MAG_W-1:0]            m1, m2;
  logic                        n1, n2;
  logic [MAG_W+TIMER_BITS-1:0] prod1, prod2;
  logic [RAW_W-1:0]            s3_raw1_q, s3_raw2_q;
  logic                        s3_neg1_q, s3_neg2_q;
  sector_e                     s3_sector_q;

  // stage 4 registers
  logic [TIMER_BITS-1:0] s4_t1_d, s4_t2_d, s4_low_d;
  logic [TIMER_BITS-1:0] s4_t1_q, s4_t2_q, s4_low_q;
  logic                  s4_sat_d, s4_sat_q;
  logic [TIMER_BITS:0]   on_sum, zero_time;
  sector_e               s4_sector_q;

  // stage 5 (output) registers
  logic [TIMER_BITS:0]   mid_sum, top_sum;
  logic [TIMER_BITS-1:0] mid, top;
  out_t                  s5_out_d, s5_out_q;

  // ---------------------------------------------------------------------------
  // handshake: a stage loads when it is empty or its successor moves on
  // ---------------------------------------------------------------------------
  assign rdy5 = !v5_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v5_q;
  assign out_data_o  = s5_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= HALF_PERIOD_RST;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        h_q <= cfg_wdata_i;
      end
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: alpha in q(FRAC_BITS) and beta times the constants
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_a_d   = PROD_W'(in_data_i.alpha) <<< 16;
    s1_kb_d  = PROD_W'(K_INV_SQRT3) * PROD_W'(in_data_i.beta);
    s1_k2b_d = PROD_W'(K_TWO_INV_SQRT3) * PROD_W'(in_data_i.beta);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_a_q   <= s1_a_d;
      s1_kb_q  <= s1_kb_d;
      s1_k2b_q <= s1_k2b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: sector from signs, projections as magnitude and sign
  // ---------------------------------------------------------------------------
  always_comb begin
    dif = s1_a_q - s1_kb_q;
    sum = s1_a_q + s1_kb_q;
    // kb > a is dif < 0, -kb > a is sum < 0; kb carries the sign of beta
    unique case ({s1_kb_q[PROD_W-1], s1_a_q[PROD_W-1]})
      2'b00:   s2_sector_d = dif[PROD_W-1] ? SEC_2 : SEC_1;
      2'b01:   s2_sector_d = sum[PROD_W-1] ? SEC_3 : SEC_2;
      2'b10:   s2_sector_d = sum[PROD_W-1] ? SEC_5 : SEC_6;
      default: s2_sector_d = dif[PROD_W-1] ? SEC_4 : SEC_5;
    endcase
    s2_mag_d_d = dif[PROD_W-1] ? MAG_W'(-dif) : MAG_W'(dif);
    s2_mag_s_d = sum[PROD_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    s2_mag_k_d = s1_k2b_q[PROD_W-1] ? MAG_W'(-s1_k2b_q) : MAG_W'(s1_k2b_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_sector_q <= s2_sector_d;
      s2_mag_d_q  <= s2_mag_d_d;
      s2_mag_s_q  <= s2_mag_s_d;
      s2_mag_k_q  <= s2_mag_k_d;
      s2_neg_d_q  <= dif[PROD_W-1];
      s2_neg_s_q  <= sum[PROD_W-1];
      s2_neg_k_q  <= s1_k2b_q[PROD_W-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pick the two active vectors and scale by the half period
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (s2_sector_q)
      SEC_1: begin
        m1 = s2_mag_d_q; n1 = s2_neg_d_q;
        m2 = s2_mag_k_q; n2 = s2_neg_k_q;
      end
      SEC_2: begin
        m1 = s2_mag_d_q; n1 = !s2_neg_d_q;
        m2 = s2_mag_s_q; n2 = s2_neg_s_q;
      end
      SEC_3: begin
        m1 = s2_mag_k_q; n1 = s2_neg_k_q;
        m2 = s2_mag_s_q; n2 = !s2_neg_s_q;
      end
      SEC_4: begin
        m1 = s2_mag_k_q; n1 = !s2_neg_k_q;
        m2 = s2_mag_d_q; n2 = !s2_neg_d_q;
      end
      SEC_5: begin
        m1 = s2_mag_s_q; n1 = !s2_neg_s_q;
        m2 = s2_mag_d_q; n2 = s2_neg_d_q;
      end
      default: begin
        m1 = s2_mag_s_q; n1 = s2_neg_s_q;
        m2 = s2_mag_k_q; n2 = !s2_neg_k_q;
      end
    endcase
    prod1 = (MAG_W+TIMER_BITS)'(m1) * (MAG_W+TIMER_BITS)'(h_q);
    prod2 = (MAG_W+TIMER_BITS)'(m2) * (MAG_W+TIMER_BITS)'(h_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_raw1_q   <= prod1[MAG_W+TIMER_BITS-1:FRAC_BITS];
      s3_raw2_q   <= prod2[MAG_W+TIMER_BITS-1:FRAC_BITS];
      s3_neg1_q   <= n1;
      s3_neg2_q   <= n2;
      s3_sector_q <= s2_sector_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: clamp on-times, halved zero-vector time
  // ---------------------------------------------------------------------------
  always_comb begin
    s4_sat_d = 1'b0;
    if (s3_neg1_q) begin
      s4_t1_d  = '0;
      s4_sat_d = (s3_raw1_q != '0);
    end else if (s3_raw1_q > RAW_W'(h_q)) begin
      s4_t1_d  = h_q;
      s4_sat_d = 1'b1;
    end else begin
      s4_t1_d  = TIMER_BITS'(s3_raw1_q);
    end
    if (s3_neg2_q) begin
      s4_t2_d = '0;
      if (s3_raw2_q != '0) s4_sat_d = 1'b1;
    end else if (s3_raw2_q > RAW_W'(h_q)) begin
      s4_t2_d  = h_q;
      s4_sat_d = 1'b1;
    end else begin
      s4_t2_d  = TIMER_BITS'(s3_raw2_q);
    end
    on_sum    = (TIMER_BITS+1)'(s4_t1_d) + (TIMER_BITS+1)'(s4_t2_d);
    zero_time = (TIMER_BITS+1)'(h_q) - on_sum;
    if (on_sum > (TIMER_BITS+1)'(h_q)) begin
      s4_low_d = '0;
      s4_sat_d = 1'b1;
    end else begin
      s4_low_d = zero_time[TIMER_BITS:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_t1_q     <= s4_t1_d;
      s4_t2_q     <= s4_t2_d;
      s4_low_q    <= s4_low_d;
      s4_sat_q    <= s4_sat_d;
      s4_sector_q <= s3_sector_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: running sums and assignment to phases
  // ---------------------------------------------------------------------------
  always_comb begin
    mid_sum = (TIMER_BITS+1)'(s4_low_q) + (TIMER_BITS+1)'(s4_t1_q);
    mid     = (mid_sum > (TIMER_BITS+1)'(h_q)) ? h_q : TIMER_BITS'(mid_sum);
    top_sum = (TIMER_BITS+1)'(mid) + (TIMER_BITS+1)'(s4_t2_q);
    top     = (top_sum > (TIMER_BITS+1)'(h_q)) ? h_q : TIMER_BITS'(top_sum);

    s5_out_d.sector    = s4_sector_q;
    s5_out_d.saturated = s4_sat_q || (mid_sum > (TIMER_BITS+1)'(h_q)) ||
                         (top_sum > (TIMER_BITS+1)'(h_q));
    unique case (s4_sector_q)
      SEC_1: begin
        s5_out_d.compare_a = s4_low_q; s5_out_d.compare_b = mid; s5_out_d.compare_c = top;
      end
      SEC_2: begin
        s5_out_d.compare_b = s4_low_q; s5_out_d.compare_a = mid; s5_out_d.compare_c = top;
      end
      SEC_3: begin
        s5_out_d.compare_b = s4_low_q; s5_out_d.compare_c = mid; s5_out_d.compare_a = top;
      end
      SEC_4: begin
        s5_out_d.compare_c = s4_low_q; s5_out_d.compare_b = mid; s5_out_d.compare_a = top;
      end
      SEC_5: begin
        s5_out_d.compare_c = s4_low_q; s5_out_d.compare_a = mid; s5_out_d.compare_b = top;
      end
      default: begin
        s5_out_d.compare_a = s4_low_q; s5_out_d.compare_c = mid; s5_out_d.compare_b = top;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      s5_out_q <= s5_out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_RST(a_cmp_in_range, clk_i, rst_ni, out_valid_o |-> (out_data_o.compare_a <= h_q && out_data_o.compare_b <= h_q && out_data_o.compare_c <= h_q), "compare value above half period")
  `ASSERT_RST(a_no_drop, clk_i, rst_ni, v5_q && out_stall_i && v4_q |=> v4_q && v5_q, "request lost in a stalled pipeline")
  `ASSERT_RST(a_stall_full, clk_i, rst_ni, in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q), "input stalled with a free stage")

endmodule

FILE: tb/sv/space_vector_pwm_timing_checker.sv
// ---------------------------------------------------------------------------
// space_vector_pwm_timing_checker
// watches the request, result and half period ports of the svpwm timing
// block, predicts sector, compare values and saturation for every accepted
// request and compares them with the results in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module space_vector_pwm_timing_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  svpt_pkg::in_t                   in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  svpt_pkg::out_t                  out_data_i,
  input  logic                            cfg_we_i,
  input  logic [svpt_pkg::TIMER_BITS-1:0] cfg_wdata_i,
  output int                              pending_o,
  output int                              results_o,
  output int                              saturated_o,
  output int                              fail_count_o
);
  import svpt_pkg::*;

  logic [TIMER_BITS-1:0] half_period_q;
  out_t                  expected_compares[$];
  int                    mismatches = 0;
  int                    results_seen = 0;
  int                    saturated_seen = 0;

  assign fail_count_o = mismatches;
  assign results_o    = results_seen;
  assign saturated_o  = saturated_seen;

  // projection times half period, truncated, then clamped into 0..h
  function automatic longint unsigned on_time_counts(input longint v,
                                                     input longint unsigned h,
                                                     inout logic sat);
    longint unsigned mag;
    if (v < 0) begin
      mag = (unsigned'(-v) * h) >> FRAC_BITS;
      if (mag != 0) sat = 1'b1;
      return 0;
    end
    mag = (unsigned'(v) * h) >> FRAC_BITS;
    if (mag > h) begin
      sat = 1'b1;
      return h;
    end
    return mag;
  endfunction

  function automatic out_t predict_compares(input in_t vec, input logic [TIMER_BITS-1:0] half);
    longint            a, kb, k2b, v1, v2;
    longint unsigned   h, t1, t2, low, mid, top, ca, cb, cc;
    logic              sat;
    sector_e           sec;
    out_t              res;
    a   = longint'(vec.alpha) * 65536;
    kb  = longint'(K_INV_SQRT3) * longint'(vec.beta);
    k2b = longint'(K_TWO_INV_SQRT3) * longint'(vec.beta);
    h   = 64'(half);
    sat = 1'b0;
    // zero on either axis counts as positive
    if (vec.beta >= 0) begin
      if (vec.alpha >= 0) sec = (kb > a) ? SEC_2 : SEC_1;
      else sec = (-kb > a) ? SEC_3 : SEC_2;
    end else begin
      if (vec.alpha >= 0) sec = (-kb > a) ? SEC_5 : SEC_6;
      else sec = (kb > a) ? SEC_4 : SEC_5;
    end
    case (sec)
      SEC_1: begin v1 = a - kb;  v2 = k2b;     end
      SEC_2: begin v1 = kb - a;  v2 = a + kb;  end
      SEC_3: begin v1 = k2b;     v2 = -a - kb; end
      SEC_4: begin v1 = -k2b;    v2 = kb - a;  end
      SEC_5: begin v1 = -a - kb; v2 = a - kb;  end
      default: begin v1 = a + kb; v2 = -k2b;   end
    endcase
    t1 = on_time_counts(v1, h, sat);
    t2 = on_time_counts(v2, h, sat);
    // over-modulation leaves no zero-vector time
    if (t1 + t2 > h) begin
      sat = 1'b1;
      low = 0;
    end else begin
      low = (h - t1 - t2) >> 1;
    end
    mid = low + t1;
    if (mid > h) begin
      sat = 1'b1;
      mid = h;
    end
    top = mid + t2;
    if (top > h) begin
      sat = 1'b1;
      top = h;
    end
    case (sec)
      SEC_1: begin ca = low; cb = mid; cc = top; end
      SEC_2: begin cb = low; ca = mid; cc = top; end
      SEC_3: begin cb = low; cc = mid; ca = top; end
      SEC_4: begin cc = low; cb = mid; ca = top; end
      SEC_5: begin cc = low; ca = mid; cb = top; end
      default: begin ca = low; cc = mid; cb = top; end
    endcase
    res.compare_a = ca[TIMER_BITS-1:0];
    res.compare_b = cb[TIMER_BITS-1:0];
    res.compare_c = cc[TIMER_BITS-1:0];
    res.sector    = sec;
    res.saturated = sat;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [TIMER_BITS-1:0] exp_val,
                             input logic [TIMER_BITS-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_res;
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      expected_compares.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_compares.push_back(predict_compares(in_data_i, half_period_q));
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_compares.size() == 0) begin
          $error("result with no request pending: sector %0d compares %0d %0d %0d",
                 out_data_i.sector, out_data_i.compare_a, out_data_i.compare_b,
                 out_data_i.compare_c);
          mismatches++;
        end else begin
          exp_res = expected_compares.pop_front();
          if (exp_res.saturated) saturated_seen++;
          check_field("compare_a", exp_res.compare_a, out_data_i.compare_a);
          check_field("compare_b", exp_res.compare_b, out_data_i.compare_b);
          check_field("compare_c", exp_res.compare_c, out_data_i.compare_c);
          check_field("sector", 16'(exp_res.sector), 16'(out_data_i.sector));
          check_field("saturated", 16'(exp_res.saturated), 16'(out_data_i.saturated));
        end
      end
      if (cfg_we_i) half_period_q <= cfg_wdata_i;
      pending_o <= expected_compares.size();
    end
  end

endmodule

FILE: tb/sv/space_vector_pwm_timing_tb.sv
// ---------------------------------------------------------------------------
// space_vector_pwm_timing_tb
// drives directed and random alpha/beta requests over several half periods
// with random gaps and output stalls; the checker predicts and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module space_vector_pwm_timing_tb;
  import svpt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int NUM_DIRECTED  = 24;
  localparam int NUM_SETTINGS  = 8;
  localparam int PHASE_VECTORS = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [TIMER_BITS-1:0] cfg_wdata_i;

  int pending;
  int results;
  int saturated;
  int fail_count;
  int cycles = 0;
  int directed_sent;
  int random_sent;
  int send_run = 0;
  int recv_run = 0;
  bit send_calm, recv_calm;

  // extremes, axes, sector centers and the 60 degree boundaries
  int dir_alpha[NUM_DIRECTED] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1,
                                  -1, -1, 0, 16384, -16384, 16384, -16384, 20000, 5000,
                                  -20000, -20000, -5000, 20000, 28377};
  int dir_beta[NUM_DIRECTED]  = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 1,
                                  -1, 0, -1, 28378, 28378, -28378, -28378, 5000, 20000,
                                  5000, -5000, -20000, -5000, 16384};
  logic [TIMER_BITS-1:0] half_settings[NUM_SETTINGS] = '{16'hFFFF, 16'd1, 16'd0, 16'd2,
                                                         16'd12345, 16'd0, 16'd4096,
                                                         16'd50000};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  space_vector_pwm_timing i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  space_vector_pwm_timing_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .results_o    (results),
    .saturated_o  (saturated),
    .fail_count_o (fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random wait, with calm stretches where nothing idles
  function automatic int draw_wait(inout int run, inout bit calm);
    if (run == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run  = $urandom_range(10, 40);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic in_t random_vector();
    int                   kind, a, b;
    logic signed [15:0]   raw_a, raw_b;
    in_t                  vec;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      vec = in_t'($urandom);
    end else if (kind < 7) begin
      // inside or near the hexagon
      raw_a = 16'($urandom);
      raw_b = 16'($urandom);
      vec.alpha = raw_a >>> $urandom_range(1, 4);
      vec.beta  = raw_b >>> $urandom_range(1, 4);
    end else begin
      // alpha right at beta / sqrt3, either sign
      b = int'($urandom_range(0, 65535)) - 32768;
      a = ((b * 37837) >>> 16) + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) a = -a;
      vec.alpha = 16'(a);
      vec.beta  = 16'(b);
    end
    return vec;
  endfunction

  task automatic send_vector(input in_t vec);
    int gap;
    gap = draw_wait(send_run, send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= vec;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [TIMER_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result side: stall a random while, then take the next result
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_wait(recv_run, recv_calm);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    in_t                   vec;
    logic [TIMER_BITS-1:0] half;
    directed_sent = 0;
    random_sent   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests at the reset half period
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      vec.alpha = 16'(dir_alpha[i]);
      vec.beta  = 16'(dir_beta[i]);
      send_vector(vec);
      directed_sent++;
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      half = (s == 5) ? 16'($urandom_range(1, 65535)) : half_settings[s];
      write_half_period(half);
      for (int i = 0; i < PHASE_VECTORS; i++) begin
        send_vector(random_vector());
        random_sent++;
      end
    end
    wait_idle();

    $display("sent %0d directed and %0d random vectors across %0d half period settings",
             directed_sent, random_sent, NUM_SETTINGS + 1);
    $display("checked %0d results, %0d predicted saturated, %0d mismatches",
             results, saturated, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/svpt_pkg.sv
hdl/space_vector_pwm_timing.sv
tb/sv/space_vector_pwm_timing_checker.sv
tb/sv/space_vector_pwm_timing_tb.sv
